// ----- design/bpsa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bpsa_pkg;

  localparam int MaxPages = 256;
  localparam int PageW    = $clog2(MaxPages);
  localparam int CntW     = PageW + 1;
  localparam int SlotBits = 64;
  localparam int SlotW    = $clog2(SlotBits);
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;

  localparam logic [SlotBits-1:0] NarrowMask = {{(SlotBits-32){1'b0}}, 32'hFFFF_FFFF};

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  localparam logic [1:0] StatusOk         = 2'd0;
  localparam logic [1:0] StatusOutOfPages = 2'd1;
  localparam logic [1:0] StatusNotCreated = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgMaskIsWide = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPageLimit  = 2'd1;

  typedef struct packed {
    logic             func;
    logic [PageW-1:0] page_index;
    logic [SlotW-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [PageW-1:0] granted_page;
    logic [SlotW-1:0] granted_slot;
  } rsp_t;

  typedef enum logic [1:0] {
    StIdle,
    StDecode,
    StExec,
    StLink
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic issue_rd;
    logic finish_now;
    logic exec;
    logic link_fix;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic imm;
    logic link_more;
    logic out_free;
  } sts_t;

  // Lowest set bit: first non-zero byte, then first bit in that byte.
  function automatic logic [SlotW-1:0] lowest_bit(input logic [SlotBits-1:0] v);
    logic [2:0] grp_sel;
    logic [7:0] grp_v;
    logic [2:0] bit_sel;
    grp_sel = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (v[i*8 +: 8] != 8'd0) grp_sel = 3'(i);
    end
    grp_v   = v[grp_sel*8 +: 8];
    bit_sel = 3'd7;
    for (int j = 7; j >= 0; j--) begin
      if (grp_v[j]) bit_sel = 3'(j);
    end
    return {grp_sel, bit_sel};
  endfunction

endpackage

`default_nettype wire

// ----- design/bpsa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpsa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bpsa_pkg::sts_t sts_i,
  output bpsa_pkg::cmd_t     cmd_o
);
  import bpsa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StDecode;
      end
      StDecode: begin
        if (!sts_i.imm) state_d = StExec;
        else if (sts_i.out_free) state_d = StIdle;
      end
      StExec: begin
        if (sts_i.out_free) state_d = sts_i.link_more ? StLink : StIdle;
      end
      StLink: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      StDecode: begin
        cmd_o.issue_rd   = !sts_i.imm;
        cmd_o.finish_now = sts_i.imm && sts_i.out_free;
      end
      StExec: begin
        cmd_o.exec = sts_i.out_free;
      end
      StLink: begin
        cmd_o.link_fix = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/bpsa_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpsa_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bpsa_pkg::cmd_t               cmd_i,
  output bpsa_pkg::sts_t                    sts_o,
  input  wire bpsa_pkg::req_t               req_i,
  input  wire logic                         cfg_valid_i,
  input  wire logic [bpsa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [bpsa_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output bpsa_pkg::rsp_t                    out_rsp_o
);
  import bpsa_pkg::*;

  // page store
  logic [SlotBits-1:0] bits_mem [MaxPages];
  logic [PageW-1:0]    next_mem [MaxPages];
  logic [PageW-1:0]    prev_mem [MaxPages];

  logic [SlotBits-1:0] rd_bits_q;
  logic [PageW-1:0]    rd_next_q, rd_prev_q;
  logic [PageW-1:0]    rd_addr;

  logic                bits_we, next_we, prev_we;
  logic [PageW-1:0]    bits_wa, next_wa, prev_wa;
  logic [SlotBits-1:0] bits_wd;
  logic [PageW-1:0]    next_wd, prev_wd;

  // control state
  req_t              req_q;
  logic              wide_q, wide_d;
  logic [CntW-1:0]   limit_q, limit_d;
  logic [PageW-1:0]  head_q, head_d;
  logic [CntW-1:0]   created_q, created_d;
  logic [PageW-1:0]  fix_q, fix_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_rsp_q, out_rsp_d;

  logic [CntW-1:0]     lim;
  logic                can_create, free_bad, slot_ok, out_free;
  logic [SlotBits-1:0] view, m, m_left, nb;
  logic [SlotW-1:0]    low;
  logic                page_full;
  rsp_t                res;

  assign lim        = (limit_q > CntW'(MaxPages)) ? CntW'(MaxPages) : limit_q;
  assign can_create = created_q < lim;
  assign view       = wide_q ? {SlotBits{1'b1}} : NarrowMask;
  assign free_bad   = (req_q.page_index == '0) || ({1'b0, req_q.page_index} >= created_q);
  assign slot_ok    = wide_q || (req_q.slot_index < SlotW'(32));
  assign out_free   = !out_valid_q || out_ready_i;

  assign m         = rd_bits_q & view;
  assign low       = lowest_bit(m);
  assign m_left    = m & ~(SlotBits'(1) << low);
  assign nb        = rd_bits_q | (SlotBits'(1) << req_q.slot_index);
  assign page_full = (rd_bits_q == '0);

  assign sts_o.imm       = (req_q.func == FuncAlloc) ? (head_q == '0) : (free_bad || !slot_ok);
  assign sts_o.link_more = (req_q.func == FuncFree) && page_full && (head_q != '0);
  assign sts_o.out_free  = out_free;

  assign rd_addr = (req_q.func == FuncFree) ? req_q.page_index : head_q;

  always_comb begin
    bits_we   = 1'b0;
    bits_wa   = head_q;
    bits_wd   = m_left;
    next_we   = 1'b0;
    next_wa   = rd_prev_q;
    next_wd   = rd_next_q;
    prev_we   = 1'b0;
    prev_wa   = rd_next_q;
    prev_wd   = rd_prev_q;
    head_d    = head_q;
    created_d = created_q;
    fix_d     = fix_q;
    res       = '0;

    if (cmd_i.finish_now) begin
      if (req_q.func == FuncAlloc) begin
        if (can_create) begin
          // fresh page: slot 0 goes straight out, page is the new head
          bits_we   = 1'b1;
          bits_wa   = created_q[PageW-1:0];
          bits_wd   = view & ~SlotBits'(1);
          next_we   = 1'b1;
          next_wa   = created_q[PageW-1:0];
          next_wd   = '0;
          prev_we   = 1'b1;
          prev_wa   = created_q[PageW-1:0];
          prev_wd   = '0;
          head_d    = created_q[PageW-1:0];
          created_d = created_q + CntW'(1);
          res.granted_page = created_q[PageW-1:0];
        end else begin
          res.status = StatusOutOfPages;
        end
      end else if (free_bad) begin
        res.status = StatusNotCreated;
      end
    end else if (cmd_i.exec) begin
      if (req_q.func == FuncAlloc) begin
        bits_we = 1'b1;
        if (m_left == '0) begin
          // unlink head page
          if (rd_prev_q != '0) next_we = 1'b1;
          else head_d = rd_next_q;
          if (rd_next_q != '0) prev_we = 1'b1;
        end
        if (m == '0) begin
          res.status = StatusOutOfPages;
        end else begin
          res.granted_page = head_q;
          res.granted_slot = low;
        end
      end else begin
        bits_we = 1'b1;
        bits_wa = req_q.page_index;
        bits_wd = nb;
        if (page_full) begin
          next_we = 1'b1;
          next_wa = req_q.page_index;
          next_wd = head_q;
          prev_we = 1'b1;
          prev_wa = req_q.page_index;
          prev_wd = '0;
          head_d  = req_q.page_index;
          fix_d   = head_q;
        end
      end
    end else if (cmd_i.link_fix) begin
      prev_we = 1'b1;
      prev_wa = fix_q;
      prev_wd = req_q.page_index;
    end
  end

  always_comb begin
    wide_d  = wide_q;
    limit_d = limit_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMaskIsWide: wide_d  = cfg_data_i[0];
        CfgPageLimit:  limit_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (cmd_i.finish_now || cmd_i.exec) begin
      out_valid_d = 1'b1;
      out_rsp_d   = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bits_we) bits_mem[bits_wa] <= bits_wd;
    if (cmd_i.issue_rd) rd_bits_q <= bits_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (cmd_i.issue_rd) rd_next_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (cmd_i.issue_rd) rd_prev_q <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
    fix_q     <= fix_d;
    out_rsp_q <= out_rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q      <= 1'b1;
      limit_q     <= CntW'(256);
      head_q      <= '0;
      created_q   <= CntW'(1);
      out_valid_q <= 1'b0;
    end else begin
      wide_q      <= wide_d;
      limit_q     <= limit_d;
      head_q      <= head_d;
      created_q   <= created_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

// ----- design/bitmap_page_slot_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Slot allocator over bitmap pages. Each request either allocates a slot (func 0) or frees
// the given page/slot (func 1), and gives exactly one response. One request is in flight
// at a time: a request that needs no page memory (new page created, out of pages, free of
// an uncreated page, slot beyond the page) ends after decode; an allocate from the head page
// and a plain free end after exec; a free that relinks a full page in front of an existing
// head adds a link fix-up step: the second write to the single-write-port prev-link memory.
// Page memory reads are registered, which sets the decode-then-execute step. Responses sit
// in an output register, so a request may be accepted while the previous response waits;
// it then holds in its last step until the register frees. No clearing pass after reset:
// page entries are written when a page is created or linked, before they are ever read.
// Configuration writes are always taken (ready tied high) and must only happen while idle.

module bitmap_page_slot_allocator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire bpsa_pkg::req_t                in_req_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output bpsa_pkg::rsp_t                     out_rsp_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bpsa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bpsa_pkg::CfgDataW-1:0] cfg_data_i
);
  import bpsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencer: idle -> decode -> (exec -> (link fix-up))
  bpsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // page memories, list head, page counter, config and response register
  bpsa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

  // one request at a time: busy straight after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while previous one still in flight");

  // a response is only loaded when the output register can take it
  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.exec || cmd.finish_now) |-> (!out_valid_o || out_ready_i))
    else $error("response overwrote a pending one");

  // grants only go with status ok
  a_grant_ok_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != StatusOk) |->
      (out_rsp_o.granted_page == '0) && (out_rsp_o.granted_slot == '0))
    else $error("grant reported with error status");

  // link fix-up only directly follows a free execute
  a_link_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.link_fix |-> $past(cmd.exec))
    else $error("link fix-up out of sequence");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the bitmap page slot allocator.
// Requests go in over a valid/ready channel; each accepted request is run through a
// local copy of the allocator state (page bitmaps, free-page list links, list head,
// page count, mode and limit) and the response it should give is queued. Every
// response taken from the block is checked field by field against the oldest entry.
// Directed tests walk the corner cases first, then random phases with mixed
// allocate/free traffic run under changing mode and page limit.

module tb_top;

  import bpsa_pkg::*;

  // Register indexes the block does not decode; writes to them must be dropped.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  localparam int AllocBusyPct = 35;  // chance of an idle cycle on either side

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  req_t                in_req_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  rsp_t                out_rsp_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  bitmap_page_slot_allocator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 0;
  end

  // --------------------------------------------------------------------------
  // Allocator state as the testbench sees it. Mirrors the block after reset.
  // --------------------------------------------------------------------------
  logic [SlotBits-1:0] page_bits [MaxPages];
  logic [PageW-1:0]    link_next [MaxPages];
  logic [PageW-1:0]    link_prev [MaxPages];
  logic [PageW-1:0]    list_head  = '0;
  logic [CntW-1:0]     page_count = CntW'(1);   // page 0 is the header
  logic                cfg_wide   = 1'b1;
  logic [CfgDataW-1:0] cfg_limit  = CfgDataW'(256);

  rsp_t rsp_due[$];     // responses owed by the block, oldest first
  req_t held_slots[$];  // granted slots not yet handed back, kept as ready-made frees

  int  err_count = 0;
  bit  gaps_on   = 1'b1;  // random idle cycles on both sides
  int  hold_left = 0;     // receiver hold-off still to run, in cycles

  initial begin
    for (int i = 0; i < MaxPages; i++) begin
      page_bits[i] = '0;
      link_next[i] = '0;
      link_prev[i] = '0;
    end
  end

  // Push page p on the front of the free-page list.
  function automatic void link_page(input logic [PageW-1:0] p);
    link_prev[p] = '0;
    link_next[p] = list_head;
    if (list_head != '0) link_prev[list_head] = p;
    list_head = p;
  endfunction

  function automatic void unlink_page(input logic [PageW-1:0] p);
    logic [PageW-1:0] pv;
    logic [PageW-1:0] nx;
    pv = link_prev[p];
    nx = link_next[p];
    if (pv != '0) link_next[pv] = nx;
    else list_head = nx;
    if (nx != '0) link_prev[nx] = pv;
    link_prev[p] = '0;
    link_next[p] = '0;
  endfunction

  // Applies one request to the local state and returns the response it must give.
  function automatic rsp_t predict_slot_response(input req_t r);
    rsp_t                rsp;
    logic [CntW-1:0]     lim;
    logic [PageW-1:0]    p;
    logic [SlotBits-1:0] view;
    logic [SlotBits-1:0] m;
    logic [SlotW-1:0]    b;
    logic                ok;
    logic                page_full;
    int                  slots;
    rsp   = '0;
    slots = cfg_wide ? SlotBits : 32;
    view  = cfg_wide ? {SlotBits{1'b1}} : NarrowMask;
    if (r.func == FuncAlloc) begin
      lim = (cfg_limit > MaxPages) ? CntW'(MaxPages) : cfg_limit;
      ok  = 1'b1;
      if (list_head == '0) begin
        if (page_count < lim) begin
          // fresh page, all slots of the current mode free
          page_bits[page_count[PageW-1:0]] = view;
          link_page(page_count[PageW-1:0]);
          page_count = page_count + CntW'(1);
        end else begin
          rsp.status = StatusOutOfPages;
          ok = 1'b0;
        end
      end
      if (ok) begin
        p = list_head;
        m = page_bits[p] & view;
        if (m == '0) begin
          // head page looks full under the narrow view after a mode change
          page_bits[p] = '0;
          unlink_page(p);
          rsp.status = StatusOutOfPages;
        end else begin
          b = '0;
          for (int i = SlotBits - 1; i >= 0; i--) begin
            if (m[i]) b = SlotW'(i);
          end
          m[b] = 1'b0;
          page_bits[p] = m;
          if (m == '0) unlink_page(p);
          rsp.granted_page = p;
          rsp.granted_slot = b;
        end
      end
    end else begin
      p = r.page_index;
      if (p == '0 || CntW'(p) >= page_count) begin
        rsp.status = StatusNotCreated;
      end else if (int'(r.slot_index) < slots) begin
        page_full = (page_bits[p] == '0);
        page_bits[p][r.slot_index] = 1'b1;
        if (page_full) link_page(p);
      end
      // slot beyond the page in narrow mode: dropped, status ok
    end
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %0t ns: %s got %0d want %0d", $time, what, got, want);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Response side: ready with random stalls, plus an occasional long hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= !(gaps_on && $urandom_range(99) < AllocBusyPct);
    end
  end

  always @(posedge clk_i) begin : check_rsp
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsp_due.size() == 0) begin
        report_mismatch("response with nothing owed, status", out_rsp_o.status, -1);
      end else begin
        want = rsp_due.pop_front();
        if (out_rsp_o.status !== want.status)
          report_mismatch("status", out_rsp_o.status, want.status);
        if (out_rsp_o.granted_page !== want.granted_page)
          report_mismatch("granted_page", out_rsp_o.granted_page, want.granted_page);
        if (out_rsp_o.granted_slot !== want.granted_slot)
          report_mismatch("granted_slot", out_rsp_o.granted_slot, want.granted_slot);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side. Valid stays up between back-to-back requests; it only drops
  // for an idle gap or at the end of a burst, never twice in one step.
  // --------------------------------------------------------------------------
  task automatic send_req(input req_t r);
    rsp_t rsp;
    if (gaps_on && $urandom_range(99) < AllocBusyPct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < AllocBusyPct);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    rsp = predict_slot_response(r);
    rsp_due.push_back(rsp);
    if (r.func == FuncAlloc && rsp.status == StatusOk)
      held_slots.push_back('{func: FuncFree, page_index: rsp.granted_page,
                             slot_index: rsp.granted_slot});
  endtask

  // Allocate ignores the page and slot fields, so they carry random bits.
  task automatic send_alloc();
    req_t r;
    r.func       = FuncAlloc;
    r.page_index = PageW'($urandom);
    r.slot_index = SlotW'($urandom);
    send_req(r);
  endtask

  task automatic send_free(input logic [PageW-1:0] p, input logic [SlotW-1:0] s);
    req_t r;
    r.func       = FuncFree;
    r.page_index = p;
    r.slot_index = s;
    send_req(r);
  endtask

  // Drop valid, wait for every owed response, then let the pipeline settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Only called while the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgMaskIsWide: cfg_wide  = val[0];
      CfgPageLimit:  cfg_limit = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Spare indexes must not disturb mode or limit; then narrow mode, smallest limit.
  task automatic test_register_map();
    write_reg(CfgSpareA, '1);
    write_reg(CfgSpareB, '0);
    write_reg(CfgPageLimit, CfgDataW'(2));
    write_reg(CfgMaskIsWide, CfgDataW'(0));
  endtask

  // Frees of the header page, of a page not yet made, and of the top page.
  task automatic test_uncreated_free();
    send_free(PageW'(0), SlotW'(0));
    send_free(PageW'(1), SlotW'(5));
    send_free(PageW'(255), SlotW'(63));
    wait_idle();
  endtask

  // With a limit of 2 only page 1 exists: fill all 32 narrow slots, then run out.
  task automatic test_page_limit();
    repeat (32) send_alloc();
    send_alloc();
    wait_idle();
  endtask

  // Slot 40 is beyond a narrow page and gets dropped; in wide mode it relinks
  // the full page, and freeing it again changes nothing.
  task automatic test_relink_and_double_free();
    send_free(PageW'(1), SlotW'(40));
    wait_idle();
    write_reg(CfgMaskIsWide, CfgDataW'(1));
    send_free(PageW'(1), SlotW'(40));
    send_free(PageW'(1), SlotW'(40));
    wait_idle();
  endtask

  // Back to narrow: the head page only has slot 40 free, which the narrow view
  // cannot see, so allocate unlinks it and reports out of pages.
  task automatic test_empty_view();
    write_reg(CfgMaskIsWide, CfgDataW'(0));
    send_alloc();
    send_alloc();
    wait_idle();
  endtask

  // Widest mode, largest limit: a second page appears and is reused after a free.
  task automatic test_page_growth();
    write_reg(CfgPageLimit, CfgDataW'(256));
    write_reg(CfgMaskIsWide, CfgDataW'(1));
    send_alloc();
    send_free(PageW'(2), SlotW'(63));
    send_free(PageW'(2), SlotW'(0));
    send_alloc();
    send_free(PageW'(3), SlotW'(1));
    send_alloc();
    wait_idle();
  endtask

  // Receiver stalls for a long stretch while requests keep coming, so the block
  // fills up and has to push back on the request side.
  task automatic test_output_backpressure();
    gaps_on   = 1'b0;
    hold_left = 300;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 2 && held_slots.size() != 0) send_req(held_slots.pop_front());
      else send_alloc();
    end
    wait_idle();
    gaps_on = 1'b1;
  endtask

  // Mixed traffic: mostly allocates and frees of slots actually held, some
  // malformed frees (header page, uncreated pages, random slots, double frees).
  task automatic run_mixed_phase(input int n_req, input int alloc_pct);
    int   roll;
    int   k;
    req_t r;
    for (int i = 0; i < n_req; i++) begin
      roll = $urandom_range(99);
      if (roll >= 92) begin
        r.func       = FuncFree;
        r.page_index = PageW'($urandom);
        r.slot_index = SlotW'($urandom);
        case ($urandom_range(3))
          0: r.page_index = '0;
          1: r.page_index = page_count[PageW-1:0];
          2: r.page_index = PageW'($urandom_range(1, 3));
          default: ;
        endcase
        send_req(r);
      end else if (roll >= alloc_pct && held_slots.size() != 0) begin
        k = $urandom_range(held_slots.size() - 1);
        r = held_slots[k];
        held_slots.delete(k);
        send_req(r);
      end else begin
        send_alloc();
      end
    end
    wait_idle();
  endtask

  task automatic test_random_mix();
    logic                wide;
    logic [CfgDataW-1:0] lim;
    for (int ph = 0; ph < 8; ph++) begin
      wide = 1'($urandom_range(1));
      case ($urandom_range(4))
        0: lim = CfgDataW'(2);
        1: lim = CfgDataW'(256);
        2: lim = CfgDataW'($urandom_range(2, 5));
        3: lim = CfgDataW'($urandom_range(2, 12));
        default: lim = CfgDataW'($urandom_range(2, 40));
      endcase
      // first two phases pin the extremes
      if (ph == 0) begin
        wide = 1'b0;
        lim  = CfgDataW'(2);
      end else if (ph == 1) begin
        wide = 1'b1;
        lim  = CfgDataW'(256);
      end
      gaps_on = (ph != 3);  // one phase at full rate on both sides
      write_reg(CfgMaskIsWide, CfgDataW'(wide));
      write_reg(CfgPageLimit, lim);
      run_mixed_phase(190, $urandom_range(35, 65));
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_map();
    test_uncreated_free();
    test_page_limit();
    test_relink_and_double_free();
    test_empty_view();
    test_page_growth();
    test_output_backpressure();
    test_random_mix();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
design/bpsa_pkg.sv
design/bpsa_ctrl.sv
design/bpsa_datapath.sv
design/bitmap_page_slot_allocator_top.sv
verif/tb_top.sv
